// ===== sv/first_fit_region_allocator_unit_defines.svh =====
// assertion macros used by the allocator top level
`ifndef FIRST_FIT_REGION_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_REGION_ALLOCATOR_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define FFRA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("allocator check failed");

// antecedent implies consequent in the next cycle
`define FFRA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("allocator check failed");

`endif

// ===== sv/ffra_pkg.sv =====
// shared types, constants and helpers of the first-fit region allocator
package ffra_pkg;

   localparam int TABLE_ENTRIES  = 16;
   localparam int ADDR_BITS      = 48;
   localparam int IDX_BITS       = $clog2(TABLE_ENTRIES);
   localparam int CNT_BITS       = $clog2(TABLE_ENTRIES + 1);
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 48;

   typedef logic [ADDR_BITS-1:0] addr_type;
   typedef logic [IDX_BITS-1:0]  idx_type;
   typedef logic [CNT_BITS-1:0]  cnt_type;
   typedef logic [1:0]           status_type;

   localparam logic REQ_MAP   = 1'b0;
   localparam logic REQ_UNMAP = 1'b1;

   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_NOMEM     = 2'd1;
   localparam status_type ST_NOTMAPPED = 2'd2;
   localparam status_type ST_FULL      = 2'd3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_REGION_START = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REGION_END   = 1'b1;

   typedef struct packed {
      logic     req_type;
      addr_type request_address;
      addr_type request_length;
      logic     is_private;
   } req_item_type;

   typedef struct packed {
      addr_type   granted_address;
      status_type status;
   } rsp_item_type;

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN1, S_DEC1, S_SCAN2, S_DEC2, S_WR0, S_WR1, S_WR2, S_RESP
   } state_type;

   typedef enum logic [3:0] {
      CMD_NONE, CMD_START, CMD_SCAN1, CMD_DEC1, CMD_SCAN2, CMD_DEC2,
      CMD_WR0, CMD_WR1, CMD_WR2, CMD_RESP
   } cmd_type;

   typedef struct packed {
      logic scan_last;
      logic fail1;
      logic fail2;
   } dp_status_type;

   // interval order by (lo, hi)
   function automatic logic pair_less(addr_type a_lo, addr_type a_hi,
                                      addr_type b_lo, addr_type b_hi);
      return (a_lo < b_lo) || ((a_lo == b_lo) && (a_hi < b_hi));
   endfunction

endpackage

// ===== sv/ffra_ctrl.sv =====
// sequencing state machine of the allocator
module ffra_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  ffra_pkg::dp_status_type dp_status,
   output ffra_pkg::cmd_type      cmd,
   output logic                   busy
);

   ffra_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffra_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ffra_pkg::S_IDLE: begin
            if (start) state_in = ffra_pkg::S_SCAN1;
         end
         ffra_pkg::S_SCAN1: begin
            if (dp_status.scan_last) state_in = ffra_pkg::S_DEC1;
         end
         ffra_pkg::S_DEC1: begin
            state_in = dp_status.fail1 ? ffra_pkg::S_RESP : ffra_pkg::S_SCAN2;
         end
         ffra_pkg::S_SCAN2: begin
            if (dp_status.scan_last) state_in = ffra_pkg::S_DEC2;
         end
         ffra_pkg::S_DEC2: begin
            state_in = dp_status.fail2 ? ffra_pkg::S_RESP : ffra_pkg::S_WR0;
         end
         ffra_pkg::S_WR0:  state_in = ffra_pkg::S_WR1;
         ffra_pkg::S_WR1:  state_in = ffra_pkg::S_WR2;
         ffra_pkg::S_WR2:  state_in = ffra_pkg::S_RESP;
         ffra_pkg::S_RESP: state_in = ffra_pkg::S_IDLE;
         default:          state_in = ffra_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd  = ffra_pkg::CMD_NONE;
      busy = 1'b1;
      unique case (state_ff)
         ffra_pkg::S_IDLE: begin
            busy = 1'b0;
            cmd  = start ? ffra_pkg::CMD_START : ffra_pkg::CMD_NONE;
         end
         ffra_pkg::S_SCAN1: cmd = ffra_pkg::CMD_SCAN1;
         ffra_pkg::S_DEC1:  cmd = ffra_pkg::CMD_DEC1;
         ffra_pkg::S_SCAN2: cmd = ffra_pkg::CMD_SCAN2;
         ffra_pkg::S_DEC2:  cmd = ffra_pkg::CMD_DEC2;
         ffra_pkg::S_WR0:   cmd = ffra_pkg::CMD_WR0;
         ffra_pkg::S_WR1:   cmd = ffra_pkg::CMD_WR1;
         ffra_pkg::S_WR2:   cmd = ffra_pkg::CMD_WR2;
         ffra_pkg::S_RESP:  cmd = ffra_pkg::CMD_RESP;
         default:           cmd = ffra_pkg::CMD_NONE;
      endcase
   end

endmodule

// ===== sv/ffra_dp.sv =====
// interval tables, scan logic and result register of the allocator
module ffra_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  ffra_pkg::cmd_type                      cmd,
   input  ffra_pkg::req_item_type                 req_data,
   input  logic                                   csr_we,
   input  logic [ffra_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [ffra_pkg::CSR_DATA_BITS-1:0]     csr_wdata,
   output ffra_pkg::dp_status_type                dp_status,
   output logic                                   rsp_valid,
   output ffra_pkg::rsp_item_type                 rsp_data
);

   localparam int N  = ffra_pkg::TABLE_ENTRIES;
   localparam int AB = ffra_pkg::ADDR_BITS;
   localparam int CB = ffra_pkg::CNT_BITS;

   // region registers
   ffra_pkg::addr_type region_start_ff, region_end_ff;
   ffra_pkg::addr_type load_lo, load_hi;
   logic cfg_load;

   // tables
   ffra_pkg::addr_type free_lo_ff [N];
   ffra_pkg::addr_type free_hi_ff [N];
   ffra_pkg::addr_type mapped_lo_ff [N];
   ffra_pkg::addr_type mapped_hi_ff [N];
   logic [N-1:0] free_used_ff, mapped_used_ff;

   // captured request and scan results
   ffra_pkg::req_item_type req_ff;
   ffra_pkg::idx_type idx_ff, idx_in;
   logic best_ok_ff, best_ok_in;
   ffra_pkg::idx_type best_idx_ff, best_idx_in;
   ffra_pkg::addr_type best_lo_ff, best_lo_in, best_hi_ff, best_hi_in;
   logic f_holds_ff, f_holds_in, f_first_ok_ff, f_first_ok_in;
   ffra_pkg::idx_type f_first_ff, f_first_in;
   logic m_holds_a_ff, m_holds_a_in, m_holds_b_ff, m_holds_b_in;
   logic m_e1_ok_ff, m_e1_ok_in, m_e2_ok_ff, m_e2_ok_in;
   ffra_pkg::idx_type m_e1_ff, m_e1_in, m_e2_ff, m_e2_in;
   ffra_pkg::cnt_type m_cnt_ff, m_cnt_in;
   ffra_pkg::status_type status_ff, status_in;
   logic rsp_valid_ff;
   ffra_pkg::rsp_item_type rsp_data_ff;

   // per-entry read
   ffra_pkg::addr_type flo, fhi, mlo, mhi, fsize;
   logic fused, mused, is_map, scan_last;
   logic [AB:0] end_sum;
   ffra_pkg::addr_type uend, map_end;
   logic end_over, a_added;
   logic [CB:0] need, avail;
   ffra_pkg::status_type code1;

   // table write controls
   logic f_clr, f_wr, m_clr, m_wr;
   ffra_pkg::idx_type f_widx, m_widx;
   ffra_pkg::addr_type f_wlo, f_whi, m_wlo, m_whi;

   assign cfg_load = csr_we;
   assign load_lo  = reset ? '0 :
                     (csr_index == ffra_pkg::CSR_REGION_START) ? AB'(csr_wdata)
                                                                : region_start_ff;
   assign load_hi  = reset ? '0 :
                     (csr_index == ffra_pkg::CSR_REGION_END) ? AB'(csr_wdata)
                                                              : region_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         region_start_ff <= '0;
         region_end_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            ffra_pkg::CSR_REGION_START: region_start_ff <= AB'(csr_wdata);
            ffra_pkg::CSR_REGION_END:   region_end_ff   <= AB'(csr_wdata);
            default: ;
         endcase
      end
   end

   assign is_map    = (req_ff.req_type == ffra_pkg::REQ_MAP);
   assign flo       = free_lo_ff[idx_ff];
   assign fhi       = free_hi_ff[idx_ff];
   assign fused     = free_used_ff[idx_ff];
   assign mlo       = mapped_lo_ff[idx_ff];
   assign mhi       = mapped_hi_ff[idx_ff];
   assign mused     = mapped_used_ff[idx_ff];
   assign fsize     = (fhi >= flo) ? (fhi - flo) : '0;
   assign end_sum   = {1'b0, req_ff.request_address} + {1'b0, req_ff.request_length};
   assign end_over  = end_sum[AB];
   assign uend      = end_sum[AB-1:0];
   assign map_end   = best_lo_ff + req_ff.request_length;
   assign scan_last = (idx_ff == ffra_pkg::idx_type'(N - 1));
   assign a_added   = (best_lo_ff != req_ff.request_address) && !m_holds_a_ff;

   assign need  = (CB+1)'(best_lo_ff != req_ff.request_address)
                + (CB+1)'(uend != best_hi_ff);
   assign avail = {1'b0, m_cnt_ff} + (CB+1)'(1);

   always_comb begin
      code1 = ffra_pkg::ST_OK;
      if (is_map) begin
         if (!req_ff.is_private || (req_ff.request_address != '0) || !best_ok_ff)
            code1 = ffra_pkg::ST_NOMEM;
      end else begin
         if (end_over || !best_ok_ff)
            code1 = ffra_pkg::ST_NOTMAPPED;
         else if (need > avail)
            code1 = ffra_pkg::ST_FULL;
         else if (!f_first_ok_ff && !f_holds_ff)
            code1 = ffra_pkg::ST_FULL;
      end
   end

   assign dp_status.scan_last = scan_last;
   assign dp_status.fail1     = (code1 != ffra_pkg::ST_OK);
   assign dp_status.fail2     = is_map && !m_e1_ok_ff && !m_holds_a_ff;

   // scan bookkeeping and decision status
   always_comb begin
      idx_in       = idx_ff;
      best_ok_in   = best_ok_ff;
      best_idx_in  = best_idx_ff;
      best_lo_in   = best_lo_ff;
      best_hi_in   = best_hi_ff;
      f_holds_in   = f_holds_ff;
      f_first_ok_in = f_first_ok_ff;
      f_first_in   = f_first_ff;
      m_holds_a_in = m_holds_a_ff;
      m_holds_b_in = m_holds_b_ff;
      m_e1_ok_in   = m_e1_ok_ff;
      m_e2_ok_in   = m_e2_ok_ff;
      m_e1_in      = m_e1_ff;
      m_e2_in      = m_e2_ff;
      m_cnt_in     = m_cnt_ff;
      status_in    = status_ff;
      case (cmd)
         ffra_pkg::CMD_START: begin
            idx_in        = '0;
            best_ok_in    = 1'b0;
            f_holds_in    = 1'b0;
            f_first_ok_in = 1'b0;
            m_holds_a_in  = 1'b0;
            m_holds_b_in  = 1'b0;
            m_e1_ok_in    = 1'b0;
            m_e2_ok_in    = 1'b0;
            m_cnt_in      = '0;
            status_in     = ffra_pkg::ST_OK;
         end
         ffra_pkg::CMD_SCAN1: begin
            idx_in = scan_last ? '0 : idx_ff + ffra_pkg::idx_type'(1);
            if (is_map) begin
               // lowest free interval that is long enough
               if (fused && (fsize >= req_ff.request_length) &&
                   (!best_ok_ff || ffra_pkg::pair_less(flo, fhi, best_lo_ff, best_hi_ff))) begin
                  best_ok_in  = 1'b1;
                  best_idx_in = idx_ff;
                  best_lo_in  = flo;
                  best_hi_in  = fhi;
               end
            end else begin
               // lowest mapped interval enclosing the range
               if (mused && (req_ff.request_address >= mlo) && (uend <= mhi) &&
                   (!best_ok_ff || ffra_pkg::pair_less(mlo, mhi, best_lo_ff, best_hi_ff))) begin
                  best_ok_in  = 1'b1;
                  best_idx_in = idx_ff;
                  best_lo_in  = mlo;
                  best_hi_in  = mhi;
               end
               if (!fused && !f_first_ok_ff) begin
                  f_first_ok_in = 1'b1;
                  f_first_in    = idx_ff;
               end
               if (fused && (flo == req_ff.request_address) && (fhi == uend))
                  f_holds_in = 1'b1;
               if (!mused) m_cnt_in = m_cnt_ff + ffra_pkg::cnt_type'(1);
            end
         end
         ffra_pkg::CMD_SCAN2: begin
            idx_in = scan_last ? '0 : idx_ff + ffra_pkg::idx_type'(1);
            if (is_map) begin
               // best entry counts as free once it is taken
               if (fused && (idx_ff != best_idx_ff) && (flo == map_end) && (fhi == best_hi_ff))
                  f_holds_in = 1'b1;
               if ((!fused || (idx_ff == best_idx_ff)) && !f_first_ok_ff) begin
                  f_first_ok_in = 1'b1;
                  f_first_in    = idx_ff;
               end
               if (mused && (mlo == best_lo_ff) && (mhi == map_end))
                  m_holds_a_in = 1'b1;
               if (!mused && !m_e1_ok_ff) begin
                  m_e1_ok_in = 1'b1;
                  m_e1_in    = idx_ff;
               end
            end else begin
               // hit entry counts as free once it is dropped
               if (mused && (idx_ff != best_idx_ff)) begin
                  if ((mlo == best_lo_ff) && (mhi == req_ff.request_address))
                     m_holds_a_in = 1'b1;
                  if ((mlo == uend) && (mhi == best_hi_ff))
                     m_holds_b_in = 1'b1;
               end else begin
                  if (!m_e1_ok_ff) begin
                     m_e1_ok_in = 1'b1;
                     m_e1_in    = idx_ff;
                  end else if (!m_e2_ok_ff) begin
                     m_e2_ok_in = 1'b1;
                     m_e2_in    = idx_ff;
                  end
               end
            end
         end
         ffra_pkg::CMD_DEC1: status_in = code1;
         ffra_pkg::CMD_DEC2: status_in = dp_status.fail2 ? ffra_pkg::ST_FULL : ffra_pkg::ST_OK;
         default: ;
      endcase
   end

   // table updates, one per table per cycle
   always_comb begin
      f_clr  = 1'b0;
      f_wr   = 1'b0;
      m_clr  = 1'b0;
      m_wr   = 1'b0;
      f_widx = best_idx_ff;
      m_widx = best_idx_ff;
      f_wlo  = map_end;
      f_whi  = best_hi_ff;
      m_wlo  = best_lo_ff;
      m_whi  = map_end;
      case (cmd)
         ffra_pkg::CMD_WR0: begin
            if (is_map) f_clr = 1'b1;
            else        m_clr = 1'b1;
         end
         ffra_pkg::CMD_WR1: begin
            if (is_map) begin
               f_wr   = (map_end != best_hi_ff) && !f_holds_ff;
               f_widx = f_first_ff;
            end else begin
               m_wr   = a_added;
               m_widx = m_e1_ff;
               m_wlo  = best_lo_ff;
               m_whi  = req_ff.request_address;
               f_wr   = !f_holds_ff;
               f_widx = f_first_ff;
               f_wlo  = req_ff.request_address;
               f_whi  = uend;
            end
         end
         ffra_pkg::CMD_WR2: begin
            if (is_map) begin
               m_wr   = !m_holds_a_ff;
               m_widx = m_e1_ff;
            end else begin
               m_wr   = (uend != best_hi_ff) && !m_holds_b_ff;
               m_widx = a_added ? m_e2_ff : m_e1_ff;
               m_wlo  = uend;
               m_whi  = best_hi_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset || cfg_load) begin
         free_used_ff   <= N'(1);
         mapped_used_ff <= '0;
      end else begin
         if (f_clr) free_used_ff[f_widx]   <= 1'b0;
         if (f_wr)  free_used_ff[f_widx]   <= 1'b1;
         if (m_clr) mapped_used_ff[m_widx] <= 1'b0;
         if (m_wr)  mapped_used_ff[m_widx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cfg_load) begin
         free_lo_ff[0] <= load_lo;
         free_hi_ff[0] <= load_hi;
      end else if (f_wr) begin
         free_lo_ff[f_widx] <= f_wlo;
         free_hi_ff[f_widx] <= f_whi;
      end
      if (m_wr) begin
         mapped_lo_ff[m_widx] <= m_wlo;
         mapped_hi_ff[m_widx] <= m_whi;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd == ffra_pkg::CMD_START) req_ff <= req_data;
      idx_ff        <= idx_in;
      best_ok_ff    <= best_ok_in;
      best_idx_ff   <= best_idx_in;
      best_lo_ff    <= best_lo_in;
      best_hi_ff    <= best_hi_in;
      f_holds_ff    <= f_holds_in;
      f_first_ok_ff <= f_first_ok_in;
      f_first_ff    <= f_first_in;
      m_holds_a_ff  <= m_holds_a_in;
      m_holds_b_ff  <= m_holds_b_in;
      m_e1_ok_ff    <= m_e1_ok_in;
      m_e2_ok_ff    <= m_e2_ok_in;
      m_e1_ff       <= m_e1_in;
      m_e2_ff       <= m_e2_in;
      m_cnt_ff      <= m_cnt_in;
      status_ff     <= status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (cmd == ffra_pkg::CMD_RESP);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd == ffra_pkg::CMD_RESP) begin
         rsp_data_ff.status          <= status_ff;
         rsp_data_ff.granted_address <= (is_map && (status_ff == ffra_pkg::ST_OK))
                                        ? best_lo_ff : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== sv/first_fit_region_allocator_unit.sv =====
// top level of the first-fit region allocator
//
//   channel   direction  handshake             payload
//   request   in         start && !busy        req_data  (req_item_type)
//   response  out        rsp_valid, one cycle  rsp_data  (rsp_item_type)
//   csr       in         csr_we                csr_index, csr_wdata
//
// when a request passes both checks, the response strobe follows both table scans, both
// decide steps, the write steps and the respond state; busy drops in the strobe cycle, so
// a new request is taken no earlier than the strobe of the last one; a request that fails
// after the first scan responds without the second scan, and a map that finds the mapped
// table full responds without the writes; the scans step through the tables one entry per cycle
// reset is synchronous and active high; it loads the free table with [0, 0)
// any csr write reloads the tables from the region registers and the written value, no clearing pass
// the response is shown for one cycle and cannot be stalled
`include "first_fit_region_allocator_unit_defines.svh"

module first_fit_region_allocator_unit (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                start,
   output logic                                busy,
   input  ffra_pkg::req_item_type              req_data,
   // response channel
   output logic                                rsp_valid,
   output ffra_pkg::rsp_item_type              rsp_data,
   // configuration port
   input  logic                                csr_we,
   input  logic [ffra_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [ffra_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   // command and status between sequencer and datapath
   ffra_pkg::cmd_type       cmd;
   ffra_pkg::dp_status_type dp_status;

   // sequencer: scan, decide, scan, decide, three write steps, respond; a failed decide goes to respond
   ffra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .dp_status (dp_status),
      .cmd       (cmd),
      .busy      (busy)
   );

   // tables and scan registers
   ffra_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .dp_status (dp_status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // an accepted request keeps the block busy
   `FFRA_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   // response lands once the sequencer is back in idle
   `FFRA_ASSERT_NOW(a_rsp_idle, clock, reset, rsp_valid, !busy)
   // a strobe is never followed at once by another
   `FFRA_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid)
   // a granted address only comes with ok status
   `FFRA_ASSERT_NOW(a_grant_ok, clock, reset,
      rsp_valid && (rsp_data.granted_address != '0), rsp_data.status == ffra_pkg::ST_OK)

endmodule

// ===== tb/first_fit_region_allocator_unit_tb.sv =====
// testbench of the first-fit region allocator: directed and random requests checked against a predictor
`timescale 1ns / 1ps

module first_fit_region_allocator_unit_tb;

   localparam int N = ffra_pkg::TABLE_ENTRIES;
   localparam logic [63:0] AMASK = (64'h1 << ffra_pkg::ADDR_BITS) - 1;
   localparam int WATCHDOG_LIMIT = 2000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   ffra_pkg::req_item_type req_data = '0;
   logic rsp_valid;
   ffra_pkg::rsp_item_type rsp_data;
   logic csr_we = 1'b0;
   logic [ffra_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [ffra_pkg::CSR_DATA_BITS-1:0] csr_wdata = '0;

   always #5 clock = ~clock;

   first_fit_region_allocator_unit uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // predictor state: region registers and both interval tables
   logic [63:0] reg_start, reg_end;
   logic [63:0] fr_lo[N], fr_hi[N], mp_lo[N], mp_hi[N];
   bit fr_used[N], mp_used[N];

   ffra_pkg::req_item_type pending_requests[$];
   ffra_pkg::rsp_item_type expected_responses[$];
   int failures = 0;
   bit idle_ok = 1'b1;     // random sender gaps allowed
   bit hold_sender = 1'b0; // sender pauses (csr phases, drain pause)
   int gap_left = 0;
   int quiet_cycles = 0;

   function automatic void queue_request(ffra_pkg::req_item_type r);
      pending_requests.insert(pending_requests.size(), r);
   endfunction

   function automatic void reload_tables();
      for (int i = 0; i < N; i++) begin
         fr_used[i] = 1'b0; mp_used[i] = 1'b0;
         fr_lo[i] = 64'd0; fr_hi[i] = 64'd0; mp_lo[i] = 64'd0; mp_hi[i] = 64'd0;
      end
      fr_lo[0] = reg_start; fr_hi[0] = reg_end; fr_used[0] = 1'b1;
   endfunction

   function automatic int empty_free();
      int n = 0;
      for (int i = 0; i < N; i++) if (!fr_used[i]) n++;
      return n;
   endfunction

   function automatic int empty_mapped();
      int n = 0;
      for (int i = 0; i < N; i++) if (!mp_used[i]) n++;
      return n;
   endfunction

   function automatic bit free_has(logic [63:0] a, logic [63:0] b);
      for (int i = 0; i < N; i++) if (fr_used[i] && fr_lo[i] == a && fr_hi[i] == b) return 1'b1;
      return 1'b0;
   endfunction

   function automatic bit mapped_has(logic [63:0] a, logic [63:0] b);
      for (int i = 0; i < N; i++) if (mp_used[i] && mp_lo[i] == a && mp_hi[i] == b) return 1'b1;
      return 1'b0;
   endfunction

   // set semantics: duplicates are dropped
   function automatic void free_add(logic [63:0] a, logic [63:0] b);
      if (free_has(a, b)) return;
      for (int i = 0; i < N; i++) if (!fr_used[i]) begin
         fr_lo[i] = a; fr_hi[i] = b; fr_used[i] = 1'b1; return;
      end
   endfunction

   function automatic void mapped_add(logic [63:0] a, logic [63:0] b);
      if (mapped_has(a, b)) return;
      for (int i = 0; i < N; i++) if (!mp_used[i]) begin
         mp_lo[i] = a; mp_hi[i] = b; mp_used[i] = 1'b1; return;
      end
   endfunction

   function automatic bit lower_pair(logic [63:0] al, logic [63:0] ah,
                                     logic [63:0] bl, logic [63:0] bh);
      return al < bl || (al == bl && ah < bh);
   endfunction

   // computes the response of one request and updates the tables
   function automatic ffra_pkg::rsp_item_type allocate_or_release(ffra_pkg::req_item_type r);
      ffra_pkg::rsp_item_type o;
      logic [63:0] a, len, sz, st, e, elo, ehi;
      int best, hit, need;
      o = '0;
      a = 64'(r.request_address);
      len = 64'(r.request_length);
      if (r.req_type == ffra_pkg::REQ_MAP) begin
         if (!r.is_private || a != 64'd0) begin
            o.status = ffra_pkg::ST_NOMEM; return o;
         end
         best = -1;
         for (int i = 0; i < N; i++) begin
            if (!fr_used[i]) continue;
            sz = fr_hi[i] >= fr_lo[i] ? fr_hi[i] - fr_lo[i] : 64'd0;
            if (sz < len) continue;
            if (best < 0 || lower_pair(fr_lo[i], fr_hi[i], fr_lo[best], fr_hi[best])) best = i;
         end
         if (best < 0) begin
            o.status = ffra_pkg::ST_NOMEM; return o;
         end
         st = fr_lo[best];
         if (empty_mapped() == 0 && !mapped_has(st, st + len)) begin
            o.status = ffra_pkg::ST_FULL; return o;
         end
         fr_used[best] = 1'b0;
         if (st + len != fr_hi[best]) free_add(st + len, fr_hi[best]);
         mapped_add(st, st + len);
         o.granted_address = ffra_pkg::addr_type'(st & AMASK);
         o.status = ffra_pkg::ST_OK;
      end else begin
         e = a + len;
         if (e > AMASK) begin
            o.status = ffra_pkg::ST_NOTMAPPED; return o;
         end
         hit = -1;
         for (int i = 0; i < N; i++)
            if (mp_used[i] && a >= mp_lo[i] && e <= mp_hi[i])
               if (hit < 0 || lower_pair(mp_lo[i], mp_hi[i], mp_lo[hit], mp_hi[hit])) hit = i;
         if (hit < 0) begin
            o.status = ffra_pkg::ST_NOTMAPPED; return o;
         end
         elo = mp_lo[hit]; ehi = mp_hi[hit];
         need = int'(elo != a) + int'(e != ehi);
         if (need > empty_mapped() + 1 || (empty_free() == 0 && !free_has(a, e))) begin
            o.status = ffra_pkg::ST_FULL; return o;
         end
         mp_used[hit] = 1'b0;
         if (elo != a) mapped_add(elo, a);
         if (e != ehi) mapped_add(e, ehi);
         free_add(a, e);
         o.status = ffra_pkg::ST_OK;
      end
      return o;
   endfunction

   function automatic ffra_pkg::req_item_type make_request(logic t, logic [47:0] a,
                                                           logic [47:0] l, logic p);
      ffra_pkg::req_item_type r;
      r.req_type = t; r.request_address = a; r.request_length = l; r.is_private = p;
      return r;
   endfunction

   // driver: one request from the queue at a time, with random gaps between requests
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && busy) begin
         // request not yet taken, keep it up
      end else begin
         if (start) begin
            void'(pending_requests.pop_front());
            expected_responses.insert(expected_responses.size(),
                                      allocate_or_release(req_data));
         end
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
         end else if (!hold_sender && pending_requests.size() > 0
                      && !(idle_ok && $urandom_range(0, 5) == 0)) begin
            req_data <= pending_requests[0];
            start <= 1'b1;
         end else begin
            if (idle_ok && $urandom_range(0, 5) == 0) gap_left <= $urandom_range(1, 4);
            start <= 1'b0;
         end
      end
   end

   // monitor: every strobe is matched against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_responses.size() == 0) begin
            $error("response with no request outstanding");
            failures++;
         end else begin
            ffra_pkg::rsp_item_type x;
            x = expected_responses.pop_front();
            if (rsp_data.granted_address !== x.granted_address) begin
               $error("granted_address expected %h actual %h", x.granted_address,
                      rsp_data.granted_address);
               failures++;
            end
            if (rsp_data.status !== x.status) begin
               $error("status expected %0d actual %0d", x.status, rsp_data.status);
               failures++;
            end
         end
      end
   end

   // watchdog on cycles with no accept and no response
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic logic [47:0] rand48();
      return {16'($urandom), 32'($urandom)};
   endfunction

   // a length biased toward small values, sometimes zero or full range
   function automatic logic [47:0] rand_len();
      case ($urandom_range(0, 9))
         0: return rand48();
         1: return 48'd0;
         default: return 48'($urandom_range(1, 64));
      endcase
   endfunction

   task automatic wait_drained();
      while (pending_requests.size() != 0 || start || expected_responses.size() != 0)
         @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_region(logic [47:0] s, logic [47:0] e);
      @(posedge clock);
      csr_we <= 1'b1; csr_index <= ffra_pkg::CSR_REGION_START; csr_wdata <= s;
      @(posedge clock);
      csr_index <= ffra_pkg::CSR_REGION_END; csr_wdata <= e;
      @(posedge clock);
      csr_we <= 1'b0;
      reg_start = 64'(s); reg_end = 64'(e);
      reload_tables();
   endtask

   // random traffic against the current region: mostly valid maps and unmaps
   // of short ranges near the region base, some noise
   task automatic random_phase(int count, logic [47:0] base);
      logic [47:0] a, l;
      int k;
      for (int n = 0; n < count; n++) begin
         k = $urandom_range(0, 9);
         if (k < 4) begin
            queue_request(make_request(ffra_pkg::REQ_MAP, 48'd0, rand_len(), 1'b1));
         end else if (k < 8) begin
            a = base + 48'($urandom_range(0, 1200));
            l = 48'($urandom_range(0, 40));
            queue_request(make_request(ffra_pkg::REQ_UNMAP, a, l, 1'($urandom_range(0, 1))));
         end else if (k == 8) begin
            queue_request(make_request(ffra_pkg::REQ_MAP, rand48(), rand_len(),
                                       1'($urandom_range(0, 1))));
         end else begin
            queue_request(make_request(ffra_pkg::REQ_UNMAP, rand48(), rand48(),
                                       1'($urandom_range(0, 1))));
         end
      end
   endtask

   initial begin
      logic [47:0] base;
      reg_start = 64'd0; reg_end = 64'd0;
      reload_tables();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: a region from 1000 to 2000 hex
      hold_sender = 1'b1;
      write_region(48'h1000, 48'h2000);
      hold_sender = 1'b0;
      queue_request(make_request(ffra_pkg::REQ_MAP, 48'd0, 48'h100, 1'b1));
      // not private
      queue_request(make_request(ffra_pkg::REQ_MAP, 48'd0, 48'h100, 1'b0));
      // nonzero address
      queue_request(make_request(ffra_pkg::REQ_MAP, 48'd5, 48'h10, 1'b1));
      // no fit
      queue_request(make_request(ffra_pkg::REQ_MAP, 48'd0, 48'hFFFF_FFFF_FFFF, 1'b1));
      // zero length
      queue_request(make_request(ffra_pkg::REQ_MAP, 48'd0, 48'd0, 1'b1));
      // middle split, then the same range again, now not mapped
      queue_request(make_request(ffra_pkg::REQ_UNMAP, 48'h1010, 48'h20, 1'b0));
      queue_request(make_request(ffra_pkg::REQ_UNMAP, 48'h1010, 48'h20, 1'b0));
      // beyond the address space
      queue_request(make_request(ffra_pkg::REQ_UNMAP, 48'hFFFF_FFFF_FFFF, 48'd1, 1'b1));
      queue_request(make_request(ffra_pkg::REQ_UNMAP, 48'h1000, 48'h10, 1'b1));
      queue_request(make_request(ffra_pkg::REQ_UNMAP, 48'h1030, 48'hD0, 1'b1));
      for (int i = 0; i < 8; i++)
         queue_request(make_request(ffra_pkg::REQ_MAP, 48'd0, 48'h1, 1'b1));
      wait_drained();

      // inverted region and full-range region
      hold_sender = 1'b1;
      write_region(48'hFFFF_FFFF_FFFF, 48'd0);
      hold_sender = 1'b0;
      queue_request(make_request(ffra_pkg::REQ_MAP, 48'd0, 48'd0, 1'b1));
      queue_request(make_request(ffra_pkg::REQ_MAP, 48'd0, 48'd1, 1'b1));
      wait_drained();
      hold_sender = 1'b1;
      write_region(48'd0, 48'hFFFF_FFFF_FFFF);
      hold_sender = 1'b0;
      // many small maps then many unmaps fill both tables
      for (int i = 0; i < 18; i++)
         queue_request(make_request(ffra_pkg::REQ_MAP, 48'd0, 48'd2, 1'b1));
      for (int i = 0; i < 18; i++)
         queue_request(make_request(ffra_pkg::REQ_UNMAP, 48'(4 * i + 1), 48'd0, 1'b1));
      wait_drained();

      // random phases across several regions
      for (int ph = 0; ph < 6; ph++) begin
         hold_sender = 1'b1;
         base = (ph == 5) ? 48'hFFFF_FFFF_F000 : 48'($urandom_range(0, 32'hFFFF_0000));
         write_region(base, (ph == 5) ? 48'hFFFF_FFFF_FFFF : base + 48'($urandom_range(64, 1200)));
         hold_sender = 1'b0;
         if (ph == 5) idle_ok = 1'b0;
         random_phase(120, base);
         if (ph == 2) begin
            // sender pauses until every response is back
            while (pending_requests.size() > 60) @(posedge clock);
            hold_sender = 1'b1;
            while (start || expected_responses.size() != 0) @(posedge clock);
            hold_sender = 1'b0;
         end
         wait_drained();
      end

      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
